>>> rtl/slr_pkg.sv
package slr_pkg;

   localparam int MAX_OUT = 64;
   localparam int COUNT_BITS = $clog2(MAX_OUT + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_L,
      ST_MUL_R,
      ST_EMIT
   } slr_state_type;

   typedef struct packed {
      logic mul_en;
      logic sel_right;
   } slr_ctrl_type;

endpackage

>>> rtl/slr_lerp_unit.sv
module slr_lerp_unit #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  slr_pkg::slr_ctrl_type         ctrl,
   input  logic signed [SAMPLE_BITS-1:0] prev_left,
   input  logic signed [SAMPLE_BITS-1:0] prev_right,
   input  logic signed [SAMPLE_BITS-1:0] new_left,
   input  logic signed [SAMPLE_BITS-1:0] new_right,
   input  logic        [FRAC_BITS-1:0]   frac,
   output logic signed [SAMPLE_BITS-1:0] lerp_result
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int SUM_BITS = SAMPLE_BITS + 2;

   logic signed [SAMPLE_BITS-1:0] base_sel;
   logic signed [SAMPLE_BITS-1:0] top_sel;
   logic signed [DIFF_BITS-1:0]   diff;
   logic signed [FRAC_BITS:0]     frac_s;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [SAMPLE_BITS-1:0] base_in;
   logic signed [SAMPLE_BITS-1:0] base_ff;
   logic signed [SUM_BITS-1:0]    scaled;
   logic signed [SUM_BITS-1:0]    sum;

   // The new sample is weighted by the fraction: prev + floor((new - prev) * f / one).
   always_comb begin
      base_sel = ctrl.sel_right ? prev_right : prev_left;
      top_sel  = ctrl.sel_right ? new_right : new_left;
      diff     = $signed({top_sel[SAMPLE_BITS-1], top_sel})
               - $signed({base_sel[SAMPLE_BITS-1], base_sel});
      frac_s   = $signed({1'b0, frac});
      prod_in  = PROD_BITS'(diff * frac_s);
      base_in  = base_sel;
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
   end

   always_comb begin
      scaled      = $signed(prod_ff[PROD_BITS-1:FRAC_BITS]);
      sum         = scaled + $signed({{2{base_ff[SAMPLE_BITS-1]}}, base_ff});
      lerp_result = $signed(sum[SAMPLE_BITS-1:0]);
   end

endmodule

>>> rtl/stereo_linear_resampler_top.sv
// Stereo linear-interpolation resampler.
// Input items are signed stereo sample pairs on the req_ channel; result items
// are interpolated pairs on the rsp_ channel, with rsp_last marking the final
// result caused by one input item. Both channels use valid and stall.
// The step register (unsigned, FRAC_BITS fraction bits) is written through the
// csr_ channel, which is always ready; write it only while the block is idle.
// Each input item is accepted in idle and then checked; each result it causes
// then passes through left multiply, right multiply (two passes through the one
// shared multiplier), loading of the output register and a further check.
// The block takes no new item until it is through with the current one, and
// gives at most 64 results per item. The first item after reset and an item
// arriving while the phase is at or above one cause no result.
// The block is not ready (req_stall high) while it works on an item. When the
// receiver stalls, the finished result waits in the output register and the
// sequencer holds until that register is free.
// Reset is synchronous: the sequencer returns to idle, the previous pair and
// phase clear, the block is unprimed and step returns to one.
module stereo_linear_resampler_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS = 16,
   localparam int STEP_BITS = FRAC_BITS + 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  logic signed [SAMPLE_BITS-1:0] req_right_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic        [STEP_BITS-1:0]   csr_step
);

   localparam int PHASE_BITS = STEP_BITS + 1;
   localparam int CB = slr_pkg::COUNT_BITS;
   localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << FRAC_BITS;
   localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1) << FRAC_BITS;

   slr_pkg::slr_state_type state_ff, state_in;
   slr_pkg::slr_ctrl_type  ctrl;

   logic [STEP_BITS-1:0]          step_ff;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in, phase_sum;
   logic [CB-1:0]                 count_ff, count_in;
   logic                          primed_ff, primed_in;
   logic signed [SAMPLE_BITS-1:0] prev_left_ff, prev_left_in;
   logic signed [SAMPLE_BITS-1:0] prev_right_ff, prev_right_in;
   logic signed [SAMPLE_BITS-1:0] new_left_ff, new_left_in;
   logic signed [SAMPLE_BITS-1:0] new_right_ff, new_right_in;
   logic signed [SAMPLE_BITS-1:0] hold_left_ff, hold_left_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic signed [SAMPLE_BITS-1:0] lerp_result;
   logic                          req_accept;
   logic                          phase_lt_one;
   logic                          more_out;
   logic                          out_free;
   logic                          out_load;

   slr_lerp_unit #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_lerp (
      .clock      (clock),
      .ctrl       (ctrl),
      .prev_left  (prev_left_ff),
      .prev_right (prev_right_ff),
      .new_left   (new_left_ff),
      .new_right  (new_right_ff),
      .frac       (phase_ff[FRAC_BITS-1:0]),
      .lerp_result(lerp_result)
   );

   assign req_stall     = (state_ff != slr_pkg::ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign rsp_last      = rsp_last_ff;

   assign phase_lt_one = (phase_ff < PHASE_ONE);
   assign more_out     = phase_lt_one && (count_ff < CB'(slr_pkg::MAX_OUT));
   assign phase_sum    = phase_ff + PHASE_BITS'(step_ff);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slr_pkg::ST_IDLE: begin
            if (req_accept && primed_ff) begin
               state_in = slr_pkg::ST_CHECK;
            end
         end
         slr_pkg::ST_CHECK: begin
            state_in = more_out ? slr_pkg::ST_MUL_L : slr_pkg::ST_IDLE;
         end
         slr_pkg::ST_MUL_L: begin
            state_in = slr_pkg::ST_MUL_R;
         end
         slr_pkg::ST_MUL_R: begin
            state_in = slr_pkg::ST_EMIT;
         end
         slr_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = slr_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = slr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl          = '0;
      out_load      = 1'b0;
      phase_in      = phase_ff;
      count_in      = count_ff;
      primed_in     = primed_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      new_left_in   = new_left_ff;
      new_right_in  = new_right_ff;
      hold_left_in  = hold_left_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         slr_pkg::ST_IDLE: begin
            if (req_accept) begin
               new_left_in  = req_left_in;
               new_right_in = req_right_in;
               count_in     = '0;
               if (!primed_ff) begin
                  primed_in     = 1'b1;
                  prev_left_in  = req_left_in;
                  prev_right_in = req_right_in;
               end
            end
         end
         slr_pkg::ST_CHECK: begin
            if (!more_out) begin
               // A phase still below one after the last result is forced to one, so it becomes zero.
               phase_in      = phase_lt_one ? '0 : phase_ff - PHASE_ONE;
               prev_left_in  = new_left_ff;
               prev_right_in = new_right_ff;
            end
         end
         slr_pkg::ST_MUL_L: begin
            ctrl.mul_en = 1'b1;
         end
         slr_pkg::ST_MUL_R: begin
            ctrl.mul_en    = 1'b1;
            ctrl.sel_right = 1'b1;
            hold_left_in   = lerp_result;
         end
         slr_pkg::ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               phase_in    = phase_sum;
               count_in    = count_ff + CB'(1);
               rsp_last_in = (phase_sum >= PHASE_ONE)
                          || (count_ff == CB'(slr_pkg::MAX_OUT - 1));
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = hold_left_ff;
         rsp_right_in = lerp_result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slr_pkg::ST_IDLE;
         step_ff       <= STEP_ONE;
         phase_ff      <= '0;
         count_ff      <= '0;
         primed_ff     <= 1'b0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         primed_ff     <= primed_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            step_ff <= csr_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      new_left_ff  <= new_left_in;
      new_right_ff <= new_right_in;
      hold_left_ff <= hold_left_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

>>> tb/tb_stereo_linear_resampler_top.sv
`timescale 1ns / 100ps

module tb_stereo_linear_resampler_top;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int STEP_BITS = FRAC_BITS + 5;
   localparam logic [STEP_BITS:0] ONE = (STEP_BITS + 1)'(1) << FRAC_BITS;
   localparam int SETTLE_CYCLES = 12;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } stereo_pair_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } interp_pair_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   sample_type           req_left_in = '0;
   sample_type           req_right_in = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   sample_type           rsp_left_out;
   sample_type           rsp_right_out;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [STEP_BITS-1:0] csr_step = '0;

   stereo_pair_type      sample_queue[$];
   interp_pair_type      interp_queue[$];

   logic [STEP_BITS-1:0] step_val = ONE[STEP_BITS-1:0];
   logic [STEP_BITS:0]   phase_acc = '0;
   stereo_pair_type      prev_pair = '0;
   logic                 primed = 1'b0;

   int                   mismatch_count = 0;
   int                   send_gap = 0;
   int                   hold_left = 0;
   logic                 req_taken = 1'b0;
   logic                 calm = 1'b0;
   stereo_pair_type      next_pair;
   stereo_pair_type      seen_pair;
   interp_pair_type      got;
   interp_pair_type      want;

   stereo_linear_resampler_top #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_left_in(req_left_in),
      .req_right_in(req_right_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_left_out(rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_step(csr_step)
   );

   always #10 clock = ~clock;

   function automatic sample_type interp(input sample_type a, input sample_type b,
                                         input logic [STEP_BITS:0] f);
      longint acc;
      acc = longint'(a) * (longint'(ONE) - longint'(f)) + longint'(b) * longint'(f);
      return SAMPLE_BITS'(acc >>> FRAC_BITS);
   endfunction

   function automatic void resample_pair(input stereo_pair_type p);
      interp_pair_type r;
      int n;
      n = 0;
      if (!primed) begin
         primed = 1'b1;
         prev_pair = p;
         return;
      end
      while (phase_acc < ONE && n < slr_pkg::MAX_OUT) begin
         r.left = interp(prev_pair.left, p.left, phase_acc);
         r.right = interp(prev_pair.right, p.right, phase_acc);
         r.last = (phase_acc + step_val >= ONE) || (n == slr_pkg::MAX_OUT - 1);
         interp_queue.push_back(r);
         n++;
         phase_acc = phase_acc + step_val;
      end
      if (phase_acc < ONE) begin
         phase_acc = ONE;
      end
      phase_acc = phase_acc - ONE;
      prev_pair = p;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0: begin
            return 16'sh7fff;
         end
         1: begin
            return 16'sh8000;
         end
         default: begin
            return SAMPLE_BITS'($urandom);
         end
      endcase
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic add_pair(input sample_type l, input sample_type r);
      stereo_pair_type p;
      p.left = l;
      p.right = r;
      sample_queue.push_back(p);
   endtask

   task automatic write_step(input logic [STEP_BITS-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_step <= v;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      step_val = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || interp_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            next_pair = sample_queue.pop_front();
            req_valid <= 1'b1;
            req_left_in <= next_pair.left;
            req_right_in <= next_pair.right;
            send_gap = calm ? 0 : draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         hold_left = draw_gap();
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_stall === 1'b0;
      if (!reset && req_valid && req_stall === 1'b0) begin
         seen_pair.left = req_left_in;
         seen_pair.right = req_right_in;
         resample_pair(seen_pair);
      end
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got.left = rsp_left_out;
         got.right = rsp_right_out;
         got.last = rsp_last;
         if (interp_queue.size() == 0) begin
            note_failure($sformatf("Unexpected result item: left %0d right %0d last %b",
                                   got.left, got.right, got.last));
         end else begin
            want = interp_queue.pop_front();
            if (got !== want) begin
               note_failure($sformatf(
                  "Mismatch: expected left %0d right %0d last %b, got left %0d right %0d last %b",
                  want.left, want.right, want.last, got.left, got.right, got.last));
            end
         end
      end
   end

   initial begin
      logic [STEP_BITS-1:0] s;
      int count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset step each result repeats the previous pair exactly.
      calm = 1'b0;
      add_pair(16'sh7fff, 16'sh8000);
      add_pair(16'sh8000, 16'sh7fff);
      add_pair(16'sh0000, 16'sh0000);
      add_pair(16'sh7fff, 16'sh7fff);
      add_pair(16'sh8000, 16'sh8000);
      add_pair(-16'sd1, 16'sd1);
      settle();

      // The smallest legal step sweeps the full range in 64 results.
      write_step(STEP_BITS'(1024));
      add_pair(16'sh8000, 16'sh7fff);
      add_pair(16'sh7fff, 16'sh8000);
      settle();

      // Steps below the minimum hit the result cap and force the phase.
      write_step('0);
      add_pair(16'sh7fff, 16'sh8000);
      add_pair(16'sh1234, -16'sd4660);
      settle();
      write_step(STEP_BITS'(700));
      add_pair(16'sh8000, 16'sh7fff);
      add_pair(16'sh0000, 16'sh7fff);
      settle();

      // Steps above one leave the phase at or above one, so some later pairs emit nothing.
      write_step({STEP_BITS{1'b1}});
      add_pair(16'sh7fff, 16'sh7fff);
      add_pair(16'sh8000, 16'sh8000);
      add_pair(16'sh5555, -16'sd21846);
      add_pair(16'sh0001, 16'shffff);
      add_pair(16'sh7fff, 16'sh8000);
      settle();
      calm = 1'b1;
      write_step(STEP_BITS'(1 << 20));
      add_pair(16'sh8000, 16'sh7fff);
      add_pair(16'sh7fff, 16'sh8000);
      add_pair(16'sh0000, 16'sh0000);
      add_pair(16'sh4000, -16'sd16384);
      settle();
      calm = 1'b0;
      write_step(STEP_BITS'(98304));
      add_pair(16'sh7fff, 16'sh8000);
      add_pair(16'sh8000, 16'sh7fff);
      add_pair(16'sh2000, 16'sh6000);
      add_pair(-16'sd300, 16'sd300);
      settle();

      for (int ph = 0; ph < 7; ph++) begin
         case ($urandom_range(0, 7))
            0: s = STEP_BITS'($urandom_range(0, 1023));
            1: s = STEP_BITS'($urandom_range(1024, 8191));
            2, 3: s = STEP_BITS'($urandom_range(8192, 131072));
            4: s = STEP_BITS'($urandom_range(131072, 1 << 20));
            5: s = STEP_BITS'($urandom);
            6: s = ONE[STEP_BITS-1:0];
            default: s = STEP_BITS'($urandom_range(32768, 65536));
         endcase
         if (ph == 6) begin
            s = ONE[STEP_BITS-1:0];
         end
         count = (s < 1024) ? 8 : 20;
         calm = ($urandom_range(0, 3) == 0);
         write_step(s);
         for (int i = 0; i < count; i++) begin
            add_pair(rand_sample(), rand_sample());
         end
         settle();
      end

      if (mismatch_count == 0 && interp_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
